// File: src/clex_pkg.sv
// Shared types and constants for the C source lexer.
`default_nettype none

package clex_pkg;

   // Default configuration
   localparam int CLEX_MAX_TOKEN_LENGTH = 4095;
   localparam int CLEX_OFFSET_WIDTH     = 24;

   // Fixed field widths of the result channel
   localparam int TOKEN_KIND_W   = 5;
   localparam int TOKEN_LENGTH_W = 12;
   localparam int TOKEN_START_W  = 24;

   // Most results one source byte can produce, and result queue depth
   localparam int CLEX_MAX_RESULTS = 3;
   localparam int CLEX_QUEUE_DEPTH = 4;

   typedef logic [TOKEN_KIND_W-1:0] kind_type;

   // Token kinds
   localparam kind_type KIND_UNKNOWN   = 5'd0;
   localparam kind_type KIND_LBRACE    = 5'd1;
   localparam kind_type KIND_RBRACE    = 5'd2;
   localparam kind_type KIND_LBRACKET  = 5'd3;
   localparam kind_type KIND_RBRACKET  = 5'd4;
   localparam kind_type KIND_LPAREN    = 5'd5;
   localparam kind_type KIND_RPAREN    = 5'd6;
   localparam kind_type KIND_COLON     = 5'd7;
   localparam kind_type KIND_SEMICOLON = 5'd8;
   localparam kind_type KIND_COMMA     = 5'd9;
   localparam kind_type KIND_ASTERISK  = 5'd10;
   localparam kind_type KIND_EQUALS    = 5'd11;
   localparam kind_type KIND_IDENT     = 5'd12;
   localparam kind_type KIND_STRING    = 5'd13;
   localparam kind_type KIND_CHAR      = 5'd14;
   localparam kind_type KIND_NUMBER    = 5'd15;
   localparam kind_type KIND_END       = 5'd16;

   // Lexer modes
   typedef enum logic [3:0] {
      MODE_IDLE       = 4'd0,
      MODE_SLASH      = 4'd1,
      MODE_LINE       = 4'd2,
      MODE_BLOCK      = 4'd3,
      MODE_BLOCK_STAR = 4'd4,
      MODE_PP         = 4'd5,
      MODE_IDENT      = 4'd6,
      MODE_NUM        = 4'd7,
      MODE_STR        = 4'd8,
      MODE_STR_ESC    = 4'd9,
      MODE_CHR        = 4'd10,
      MODE_CHR_ESC    = 4'd11
   } mode_type;

   // One result token
   typedef struct packed {
      kind_type                  kind;
      logic [TOKEN_LENGTH_W-1:0] length;
      logic [TOKEN_START_W-1:0]  start;
      logic                      last;
   } result_type;

   // Results of one source byte, in order, with a valid bit each
   typedef struct packed {
      logic [CLEX_MAX_RESULTS-1:0]                valid;
      result_type [CLEX_MAX_RESULTS-1:0]          slot;
   } burst_type;

endpackage

`default_nettype wire

// File: src/clex_core.sv
// Lexer state machine: consumes one source byte and produces its token burst.
`default_nettype none

module clex_core #(
   parameter int MAX_TOKEN_LENGTH = clex_pkg::CLEX_MAX_TOKEN_LENGTH,
   parameter int OFFSET_WIDTH     = clex_pkg::CLEX_OFFSET_WIDTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          source_byte,
   input  wire logic                end_flag,
   output clex_pkg::burst_type      burst
);
   import clex_pkg::*;

   localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);

   // Character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // State registers
   mode_type                mode_ff, mode_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [OFFSET_WIDTH-1:0] start_ff, start_in;
   logic [OFFSET_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0]              prev_ff, prev_in;
   logic [7:0]              prev2_ff, prev2_in;

   // Decoded byte and step results
   logic                    is_zero, finish, is_eol, is_digit, is_word, starts_num, cont_num;
   logic                    pp_cont;
   logic [OFFSET_WIDTH-1:0] pos_inc;
   logic [LEN_W-1:0]        grow_len;
   logic                    idle_emit, idle_begin, idle_len_one;
   kind_type                idle_kind;
   mode_type                idle_mode;
   logic [OFFSET_WIDTH-1:0] idle_start;
   logic                    run_idle;
   mode_type                step_mode;
   logic [LEN_W-1:0]        step_len;
   logic [OFFSET_WIDTH-1:0] step_start;
   logic                    flush_valid;
   kind_type                flush_kind;
   logic                    close_valid;
   kind_type                close_kind;

   // Widen or trim internal values to the result fields
   function automatic logic [TOKEN_LENGTH_W-1:0] to_length(input logic [LEN_W-1:0] v);
      return TOKEN_LENGTH_W'(32'(v));
   endfunction

   function automatic logic [TOKEN_START_W-1:0] to_start(input logic [OFFSET_WIDTH-1:0] v);
      return TOKEN_START_W'(32'(v));
   endfunction

   // Classify the incoming byte
   always_comb begin
      is_zero    = (source_byte == CH_NUL);
      finish     = is_zero || end_flag;
      is_eol     = (source_byte == CH_CR) || (source_byte == CH_LF);
      is_digit   = (source_byte >= CH_0) && (source_byte <= CH_9);
      is_word    = is_digit || (source_byte == CH_UNDER) ||
                   ((source_byte >= CH_LOWER_A) && (source_byte <= CH_LOWER_Z)) ||
                   ((source_byte >= CH_UPPER_A) && (source_byte <= CH_UPPER_Z));
      starts_num = is_digit || (source_byte == CH_PLUS) || (source_byte == CH_MINUS);
      cont_num   = starts_num || (source_byte == CH_DOT) || (source_byte == CH_LOWER_X) ||
                   ((source_byte >= CH_LOWER_A) && (source_byte <= CH_LOWER_F)) ||
                   ((source_byte >= CH_UPPER_A) && (source_byte <= CH_UPPER_F));
      pp_cont    = (prev_ff == CH_BSLASH) ||
                   ((source_byte == CH_LF) && (prev_ff == CH_CR) && (prev2_ff == CH_BSLASH));
      pos_inc    = pos_ff + OFFSET_WIDTH'(1);
      grow_len   = (len_ff < LEN_W'(MAX_TOKEN_LENGTH)) ? len_ff + LEN_W'(1) : len_ff;
   end

   // Decide what a byte does between tokens
   always_comb begin
      idle_emit    = 1'b0;
      idle_kind    = KIND_UNKNOWN;
      idle_begin   = 1'b0;
      idle_mode    = MODE_IDLE;
      idle_len_one = 1'b1;
      idle_start   = pos_ff;
      case (source_byte) inside
         CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_FF: begin
         end
         CH_SLASH: begin
            idle_begin = 1'b1;
            idle_mode  = MODE_SLASH;
         end
         CH_HASH: begin
            idle_mode = MODE_PP;
         end
         CH_DQUOTE: begin
            idle_begin   = 1'b1;
            idle_mode    = MODE_STR;
            idle_len_one = 1'b0;
            idle_start   = pos_inc;
         end
         CH_SQUOTE: begin
            idle_begin   = 1'b1;
            idle_mode    = MODE_CHR;
            idle_len_one = 1'b0;
            idle_start   = pos_inc;
         end
         CH_LBRACE: begin
            idle_emit = 1'b1;
            idle_kind = KIND_LBRACE;
         end
         CH_RBRACE: begin
            idle_emit = 1'b1;
            idle_kind = KIND_RBRACE;
         end
         CH_LBRACKET: begin
            idle_emit = 1'b1;
            idle_kind = KIND_LBRACKET;
         end
         CH_RBRACKET: begin
            idle_emit = 1'b1;
            idle_kind = KIND_RBRACKET;
         end
         CH_LPAREN: begin
            idle_emit = 1'b1;
            idle_kind = KIND_LPAREN;
         end
         CH_RPAREN: begin
            idle_emit = 1'b1;
            idle_kind = KIND_RPAREN;
         end
         CH_COLON: begin
            idle_emit = 1'b1;
            idle_kind = KIND_COLON;
         end
         CH_SEMI: begin
            idle_emit = 1'b1;
            idle_kind = KIND_SEMICOLON;
         end
         CH_COMMA: begin
            idle_emit = 1'b1;
            idle_kind = KIND_COMMA;
         end
         CH_STAR: begin
            idle_emit = 1'b1;
            idle_kind = KIND_ASTERISK;
         end
         CH_EQUALS: begin
            idle_emit = 1'b1;
            idle_kind = KIND_EQUALS;
         end
         default: begin
            if (starts_num) begin
               idle_begin = 1'b1;
               idle_mode  = MODE_NUM;
            end else if (is_word) begin
               idle_begin = 1'b1;
               idle_mode  = MODE_IDENT;
            end else begin
               idle_emit = 1'b1;
            end
         end
      endcase
   end

   // Next state: advance the mode for one byte, then drop everything at stream end
   always_comb begin
      step_mode  = mode_ff;
      step_len   = len_ff;
      step_start = start_ff;
      run_idle   = 1'b0;
      if (!is_zero) begin
         unique case (mode_ff)
            MODE_SLASH: begin
               if (source_byte == CH_SLASH) step_mode = MODE_LINE;
               else if (source_byte == CH_STAR) step_mode = MODE_BLOCK;
               else run_idle = 1'b1;
            end
            MODE_LINE: begin
               if (is_eol) step_mode = MODE_IDLE;
            end
            MODE_BLOCK: begin
               if (source_byte == CH_STAR) step_mode = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
               if (source_byte == CH_SLASH) step_mode = MODE_IDLE;
               else if (source_byte != CH_STAR) step_mode = MODE_BLOCK;
            end
            MODE_PP: begin
               if (is_eol && !pp_cont) step_mode = MODE_IDLE;
            end
            MODE_IDENT: begin
               if (is_word) step_len = grow_len;
               else run_idle = 1'b1;
            end
            MODE_NUM: begin
               if (cont_num) step_len = grow_len;
               else run_idle = 1'b1;
            end
            MODE_STR: begin
               if (source_byte == CH_DQUOTE) begin
                  step_mode = MODE_IDLE;
               end else begin
                  step_len = grow_len;
                  if (source_byte == CH_BSLASH) step_mode = MODE_STR_ESC;
               end
            end
            MODE_STR_ESC: begin
               step_len  = grow_len;
               step_mode = MODE_STR;
            end
            MODE_CHR: begin
               if (source_byte == CH_SQUOTE) begin
                  step_mode = MODE_IDLE;
               end else begin
                  step_len = grow_len;
                  if (source_byte == CH_BSLASH) step_mode = MODE_CHR_ESC;
               end
            end
            MODE_CHR_ESC: begin
               step_len  = grow_len;
               step_mode = MODE_CHR;
            end
            default: begin
               run_idle = 1'b1;
            end
         endcase
         if (run_idle) begin
            step_mode = idle_mode;
            if (idle_begin) begin
               step_len   = idle_len_one ? LEN_W'(1) : '0;
               step_start = idle_start;
            end
         end
      end

      if (finish) begin
         mode_in  = MODE_IDLE;
         len_in   = '0;
         start_in = '0;
         pos_in   = '0;
         prev_in  = CH_NUL;
         prev2_in = CH_NUL;
      end else begin
         mode_in  = step_mode;
         len_in   = step_len;
         start_in = step_start;
         pos_in   = pos_inc;
         prev_in  = source_byte;
         prev2_in = prev_ff;
      end
   end

   // Outputs: close the pending token, emit the new one, then the end token
   always_comb begin
      close_valid = 1'b0;
      close_kind  = KIND_UNKNOWN;
      if (!is_zero) begin
         case (mode_ff)
            MODE_SLASH: begin
               close_valid = run_idle;
               close_kind  = KIND_UNKNOWN;
            end
            MODE_IDENT: begin
               close_valid = run_idle;
               close_kind  = KIND_IDENT;
            end
            MODE_NUM: begin
               close_valid = run_idle;
               close_kind  = KIND_NUMBER;
            end
            MODE_STR: begin
               close_valid = (source_byte == CH_DQUOTE);
               close_kind  = KIND_STRING;
            end
            MODE_CHR: begin
               close_valid = (source_byte == CH_SQUOTE);
               close_kind  = KIND_CHAR;
            end
            default: begin
            end
         endcase
      end

      flush_valid = 1'b0;
      flush_kind  = KIND_UNKNOWN;
      case (step_mode)
         MODE_SLASH: begin
            flush_valid = 1'b1;
            flush_kind  = KIND_UNKNOWN;
         end
         MODE_IDENT: begin
            flush_valid = 1'b1;
            flush_kind  = KIND_IDENT;
         end
         MODE_NUM: begin
            flush_valid = 1'b1;
            flush_kind  = KIND_NUMBER;
         end
         MODE_STR, MODE_STR_ESC: begin
            flush_valid = 1'b1;
            flush_kind  = KIND_STRING;
         end
         MODE_CHR, MODE_CHR_ESC: begin
            flush_valid = 1'b1;
            flush_kind  = KIND_CHAR;
         end
         default: begin
         end
      endcase

      // First slot: the token this byte terminates
      burst.valid[0]       = close_valid;
      burst.slot[0].kind   = close_kind;
      burst.slot[0].length = to_length(len_ff);
      burst.slot[0].start  = to_start(start_ff);

      // Second slot: a one-byte token, or the token cut off by stream end
      if (!is_zero && run_idle && idle_emit) begin
         burst.valid[1]       = 1'b1;
         burst.slot[1].kind   = idle_kind;
         burst.slot[1].length = TOKEN_LENGTH_W'(1);
         burst.slot[1].start  = to_start(pos_ff);
      end else begin
         burst.valid[1]       = finish && flush_valid;
         burst.slot[1].kind   = flush_kind;
         burst.slot[1].length = to_length(step_len);
         burst.slot[1].start  = to_start(step_start);
      end

      // Third slot: end of stream
      burst.valid[2]       = finish;
      burst.slot[2].kind   = KIND_END;
      burst.slot[2].length = '0;
      burst.slot[2].start  = to_start(is_zero ? pos_ff : pos_inc);

      // Mark the final token of the burst
      burst.slot[0].last = close_valid && !burst.valid[1] && !burst.valid[2];
      burst.slot[1].last = burst.valid[1] && !burst.valid[2];
      burst.slot[2].last = burst.valid[2];
   end

   // Hold state; advance on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         len_ff   <= '0;
         start_ff <= '0;
         pos_ff   <= '0;
         prev_ff  <= CH_NUL;
         prev2_ff <= CH_NUL;
      end else if (accept) begin
         mode_ff  <= mode_in;
         len_ff   <= len_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         prev_ff  <= prev_in;
         prev2_ff <= prev2_in;
      end
   end

endmodule

`default_nettype wire

// File: src/clex_queue.sv
// Result queue: takes a burst of up to three tokens, hands them out one per cycle while pop is high.
`default_nettype none

module clex_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire clex_pkg::burst_type  burst,
   input  wire logic                 pop,
   output logic                      room,
   output logic                      out_valid,
   output clex_pkg::result_type      out_result
);
   import clex_pkg::*;

   localparam int PTR_W = $clog2(CLEX_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(CLEX_QUEUE_DEPTH + 1);
   localparam int ROOM_LIMIT = CLEX_QUEUE_DEPTH - CLEX_MAX_RESULTS;

   result_type         entry_ff [CLEX_QUEUE_DEPTH];
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_pos1, wr_pos2;
   logic [CNT_W-1:0]   push_count;

   // Place valid slots back to back behind the write pointer
   always_comb begin
      wr_pos1    = wr_ptr_ff + PTR_W'(burst.valid[0]);
      wr_pos2    = wr_pos1 + PTR_W'(burst.valid[1]);
      push_count = push ? CNT_W'(burst.valid[0]) + CNT_W'(burst.valid[1]) +
                          CNT_W'(burst.valid[2]) : '0;
      wr_ptr_in  = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in  = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff + push_count - CNT_W'(pop);
   end

   // Take a request only when a full burst still fits after this cycle's pop
   assign room = (count_ff <= CNT_W'(ROOM_LIMIT)) ||
                 (pop && (count_ff == CNT_W'(ROOM_LIMIT + 1)));

   assign out_valid  = (count_ff != '0);
   assign out_result = entry_ff[rd_ptr_ff];

   // Store burst entries
   always_ff @(posedge clock) begin
      if (push) begin
         if (burst.valid[0]) entry_ff[wr_ptr_ff] <= burst.slot[0];
         if (burst.valid[1]) entry_ff[wr_pos1]   <= burst.slot[1];
         if (burst.valid[2]) entry_ff[wr_pos2]   <= burst.slot[2];
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: src/c_source_lexer.sv
// Top level of the streaming C source lexer.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_source_byte, req_end_flag
//   rsp_     out        rsp_valid/rsp_stall  rsp_token_kind, rsp_token_length,
//                                            rsp_token_start, rsp_run_last
//
// One source byte is taken per cycle; the lexer state updates in the same cycle
// and the byte's tokens (zero to three) enter a four-entry result queue.
// Tokens leave the queue one per cycle while rsp_stall is low, so the sustained
// rate is one byte per cycle while bytes average at most one token each; a byte
// that yields more holds the next request until enough queue entries free up.
// req_stall is high while fewer than three entries are free after this cycle.
// Reset is synchronous and clears the lexer state and the queue.
`default_nettype none

module c_source_lexer #(
   parameter int MAX_TOKEN_LENGTH = clex_pkg::CLEX_MAX_TOKEN_LENGTH,
   parameter int OFFSET_WIDTH     = clex_pkg::CLEX_OFFSET_WIDTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [7:0]                            req_source_byte,
   input  wire logic                                  req_end_flag,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [clex_pkg::TOKEN_KIND_W-1:0]          rsp_token_kind,
   output logic [clex_pkg::TOKEN_LENGTH_W-1:0]        rsp_token_length,
   output logic [clex_pkg::TOKEN_START_W-1:0]         rsp_token_start,
   output logic                                       rsp_run_last
);
   import clex_pkg::*;

   burst_type  burst;
   result_type head;
   logic       room, req_accept, rsp_accept;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = !room;

   // Lexer state and token decode
   clex_core #(
      .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
      .OFFSET_WIDTH     (OFFSET_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .source_byte (req_source_byte),
      .end_flag    (req_end_flag),
      .burst       (burst)
   );

   // Result queue
   clex_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .burst      (burst),
      .pop        (rsp_accept),
      .room       (room),
      .out_valid  (rsp_valid),
      .out_result (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_length = head.length;
   assign rsp_token_start  = head.start;
   assign rsp_run_last     = head.last;

   // A stream end always leaves at least the end token queued
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_end_flag || (req_source_byte == 8'h00)) |=> rsp_valid)
      else $error("end of stream produced no result");

   // An empty queue always has room for a request
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with an empty result queue");

   // Reset empties the queue
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending right after reset");

endmodule

`default_nettype wire
